// File: src/sab_pkg.sv
// Shared types and constants for the suffix array builder.
`default_nettype none
package sab_pkg;
  localparam int SymW = 8;
  localparam int StartW = 5;

  // Request moved from the front part to the back part through the queue.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_symbol;
  } sab_req_t;
endpackage
`default_nettype wire

// File: src/sab_if.sv
// Valid/ready channel interfaces for the input and result requests.
`default_nettype none
interface sab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;
  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface sab_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] suffix_start;
  logic       last_result;
  logic       overflow;
  modport source (output valid, output suffix_start, output last_result, output overflow,
                  input ready);
  modport sink (input valid, input suffix_start, input last_result, input overflow,
                output ready);
endinterface
`default_nettype wire

// File: src/sab_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module sab_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/sab_front.sv
// Front part: accepts input requests into a short queue.
`default_nettype none
module sab_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sab_in_if.sink        in_ch,
  output sab_pkg::sab_req_t q_data,
  output logic          q_valid,
  input  wire logic     q_pop
);
  import sab_pkg::*;
  localparam int Depth = 4;
  sab_req_t mem_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic push;

  assign in_ch.ready = (cnt_r != 3'(Depth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 3'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{symbol: in_ch.symbol, last_symbol: in_ch.last_symbol};
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (q_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(q_pop);
    end
  end
endmodule
`default_nettype wire

// File: src/sab_back.sv
// Back part: stores bytes, insertion-sorts suffixes and emits the order.
`default_nettype none
module sab_back #(
  parameter int MaxLen = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  sab_pkg::sab_req_t q_data,
  input  wire logic         q_valid,
  output logic              q_pop,
  sab_out_if.source         out_ch
);
  import sab_pkg::*;
  localparam int AW = $clog2(MaxLen);
  localparam int LW = $clog2(MaxLen + 1);

  localparam logic [3:0] S_LOAD = 4'd0, S_INIT = 4'd1, S_OUTER = 4'd2, S_KEYR = 4'd3,
                         S_PREV = 4'd4, S_CA = 4'd5, S_CMP = 4'd6, S_SHIFT = 4'd7,
                         S_PUT = 4'd8, S_ORD = 4'd9, S_EMIT = 4'd10, S_CB = 4'd11,
                         S_CC = 4'd12, S_STEP = 4'd13;
  logic [3:0] st_r;
  logic [LW-1:0] len_r, i_r, j_r, k_r;
  logic [LW-1:0] a_r, b_r;
  logic ovf_r;
  logic [AW-1:0] key_r, prev_r;
  logic [7:0] ca_r;

  logic t_we, o_we;
  logic [AW-1:0] t_wa, t_ra, o_wa, o_ra;
  logic [7:0] t_wd, t_rd;
  logic [AW-1:0] o_wd, o_rd;

  sab_ram #(.Width(8), .Depth(MaxLen)) u_text (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  sab_ram #(.Width(AW), .Depth(MaxLen)) u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  logic out_v_r, out_l_r;
  logic [AW-1:0] out_s_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.suffix_start = StartW'(out_s_r);
  assign out_ch.last_result = out_l_r;
  assign out_ch.overflow = ovf_r;

  assign q_pop = (st_r == S_LOAD) && q_valid;
  assign t_we = q_pop && (len_r != LW'(MaxLen));
  assign t_wa = len_r[AW-1:0];
  assign t_wd = q_data.symbol;
  assign t_ra = (st_r == S_CB) ? b_r[AW-1:0] : a_r[AW-1:0];

  always_comb begin
    o_we = 1'b0; o_wa = i_r[AW-1:0]; o_wd = i_r[AW-1:0]; o_ra = i_r[AW-1:0];
    case (st_r)
      S_INIT: o_we = 1'b1;
      S_OUTER: o_ra = i_r[AW-1:0];
      S_PREV: o_ra = AW'(j_r - LW'(1));
      S_SHIFT: begin o_we = 1'b1; o_wa = j_r[AW-1:0]; o_wd = prev_r; end
      S_PUT: begin o_we = 1'b1; o_wa = j_r[AW-1:0]; o_wd = key_r; end
      S_ORD, S_EMIT: o_ra = k_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; len_r <= '0; ovf_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      case (st_r)
        S_LOAD: if (q_valid) begin
          if (len_r != LW'(MaxLen)) len_r <= len_r + LW'(1);
          else ovf_r <= 1'b1;
          i_r <= '0;
          if (q_data.last_symbol) st_r <= S_INIT;
        end
        S_INIT: if (i_r + LW'(1) >= len_r) begin
          i_r <= LW'(1); st_r <= S_OUTER;
        end else i_r <= i_r + LW'(1);
        S_OUTER: if (i_r >= len_r) begin
          k_r <= '0; st_r <= S_ORD;
        end else begin
          j_r <= i_r; st_r <= S_KEYR;
        end
        S_KEYR: begin key_r <= o_rd; st_r <= (j_r == '0) ? S_PUT : S_PREV; end
        S_PREV: st_r <= S_CMP;
        S_CMP: begin
          // Operand positions: a walks the earlier entry, b the key.
          prev_r <= o_rd; a_r <= LW'(o_rd); b_r <= LW'(key_r); st_r <= S_CA;
        end
        S_CA: begin
          // Compare loop: a or b exhausted ends it; else fetch bytes.
          if (a_r >= len_r || b_r >= len_r) begin
            st_r <= (a_r < len_r) ? S_SHIFT : S_PUT;
          end else begin
            st_r <= S_CB;
          end
        end
        S_CB: begin ca_r <= t_rd; st_r <= S_CC; end
        S_CC: begin
          if (ca_r != t_rd) st_r <= (ca_r > t_rd) ? S_SHIFT : S_PUT;
          else begin a_r <= a_r + LW'(1); b_r <= b_r + LW'(1); st_r <= S_STEP; end
        end
        S_STEP: st_r <= S_CA;
        S_SHIFT: begin
          j_r <= j_r - LW'(1);
          st_r <= (j_r == LW'(1)) ? S_PUT : S_PREV;
        end
        S_PUT: begin i_r <= i_r + LW'(1); st_r <= S_OUTER; end
        S_ORD: st_r <= S_EMIT;
        S_EMIT: if (!out_v_r) begin
          out_v_r <= 1'b1; out_s_r <= o_rd; out_l_r <= (k_r + LW'(1) == len_r);
        end else if (out_ch.ready) begin
          out_v_r <= 1'b0;
          if (out_l_r) begin
            len_r <= '0; ovf_r <= 1'b0; st_r <= S_LOAD;
          end else begin
            k_r <= k_r + LW'(1); st_r <= S_ORD;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/suffix_array_builder_unit.sv
// Top level of the suffix array builder.
`default_nettype none
// Bytes arrive one per request into a four-entry queue and are stored one per
// cycle by the back part while it is loading; the final byte starts an
// insertion sort of suffix start positions held in a RAM, comparing two
// suffixes one byte pair at a time through the single text RAM read port.
// Results are then offered one at a time, the next read only once the
// receiver has taken the last. Bytes beyond MAX_LEN are dropped and flagged
// as overflow on every result of that string. A string of only overflowing
// bytes never occurs. MAX_LEN must be at least two; the block does not check.
module suffix_array_builder_unit #(
  parameter int MAX_LEN = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  sab_in_if.sink    in_ch,
  sab_out_if.source out_ch
);
  import sab_pkg::*;
  sab_req_t q_data;
  logic q_valid, q_pop;

  sab_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));
  sab_back #(.MaxLen(MAX_LEN)) u_back (.clk(clk), .rst_n(rst_n),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch));
endmodule
`default_nettype wire

// File: bench/suffix_order_checker.sv
// Checker that predicts the sorted suffix order of each string and compares the results.
`default_nettype none
module suffix_order_checker #(
  parameter int MAX_LEN = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  sab_in_if        in_ch,
  sab_out_if       out_ch,
  output int       fail_count,
  output int       outstanding
);
  import sab_pkg::*;

  typedef struct {
    logic [StartW-1:0] suffix_start;
    logic              last_result;
    logic              overflow;
  } suffix_result_t;

  logic [SymW-1:0] text_bytes[MAX_LEN];
  int              text_len;
  bit              dropped;
  suffix_result_t  pending_suffixes[$];

  // True when the suffix at a orders after the suffix at b.
  function automatic bit orders_after(int a, int b, int len);
    while (a < len && b < len) begin
      if (text_bytes[a] != text_bytes[b]) return text_bytes[a] > text_bytes[b];
      a++;
      b++;
    end
    return a < len;
  endfunction

  task automatic queue_sorted_suffixes();
    int order[MAX_LEN];
    int key;
    int j;
    suffix_result_t r;
    for (int i = 0; i < text_len; i++) order[i] = i;
    for (int i = 1; i < text_len; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && orders_after(order[j-1], key, text_len)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (int k = 0; k < text_len; k++) begin
      r.suffix_start = order[k][StartW-1:0];
      r.last_result = (k == text_len - 1);
      r.overflow = dropped;
      pending_suffixes.push_back(r);
    end
  endtask

  assign outstanding = pending_suffixes.size();

  always @(posedge clk) begin
    suffix_result_t want;
    if (!rst_n) begin
      text_len = 0;
      dropped = 0;
      fail_count = 0;
      pending_suffixes.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_suffixes.size() == 0) begin
          $error("unexpected result: suffix_start %0d", out_ch.suffix_start);
          fail_count++;
        end else begin
          want = pending_suffixes.pop_front();
          if (out_ch.suffix_start !== want.suffix_start) begin
            $error("suffix_start: expected %0d, got %0d", want.suffix_start,
                   out_ch.suffix_start);
            fail_count++;
          end
          if (out_ch.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result,
                   out_ch.last_result);
            fail_count++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (text_len < MAX_LEN) begin
          text_bytes[text_len] = in_ch.symbol;
          text_len++;
        end else begin
          dropped = 1;
        end
        if (in_ch.last_symbol) begin
          queue_sorted_suffixes();
          text_len = 0;
          dropped = 0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: bench/tb.sv
// Top of the suffix array builder testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
  import sab_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   send_idle_on;
  bit   recv_idle_on;
  bit   hold_results;
  int   items_sent;

  sab_in_if  in_ch();
  sab_out_if out_ch();

  suffix_array_builder_unit #(.MAX_LEN(32)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  suffix_order_checker #(.MAX_LEN(32)) chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // A hard stop well beyond the slowest legal run, including worst-case sorts.
  initial begin
    #100000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side. A hold request makes the receiver refuse results for a long
  // stretch it counts itself, so the block backs up and stalls its input.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end else begin
        out_ch.ready <= !recv_idle_on || ($urandom_range(99) >= 22);
      end
    end
  end

  // Offer one byte; random gaps are inserted before it while idling is on.
  // Valid is only dropped inside a gap, so it never toggles within one step.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic fin);
    while (send_idle_on && $urandom_range(99) < 22) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.symbol <= sym;
    in_ch.last_symbol <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // A whole string of n bytes, drawn from a small alphabet when repeats are
  // wanted so that long common prefixes show up in the comparisons.
  task automatic send_string(input int n, input bit repeats);
    logic [SymW-1:0] sym;
    for (int i = 0; i < n; i++) begin
      sym = repeats ? SymW'($urandom_range(3, 1)) : SymW'($urandom_range(255, 1));
      send_symbol(sym, i == n - 1);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.symbol = 0;
    in_ch.last_symbol = 0;
    send_idle_on = 1;
    recv_idle_on = 1;
    hold_results = 0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed strings: a single top byte, equal bytes where each suffix is a
    // prefix of the one before, a zero byte among extremes, and mixed patterns.
    send_symbol(8'hFF, 1);
    send_symbol(8'h01, 1);
    send_symbol(8'h01, 0);
    send_symbol(8'h01, 0);
    send_symbol(8'h01, 1);
    send_symbol(8'h80, 0);
    send_symbol(8'h01, 0);
    send_symbol(8'h00, 0);
    send_symbol(8'hFF, 0);
    send_symbol(8'h80, 1);
    send_symbol(8'h55, 0);
    send_symbol(8'hAA, 0);
    send_symbol(8'h55, 0);
    send_symbol(8'hAA, 0);
    send_symbol(8'h7F, 0);
    send_symbol(8'hFE, 1);
    // Sender pauses until every pending result has come back.
    drain();

    // Back-pressure: results are refused while the next string keeps coming.
    hold_results = 1;
    send_string(5, 1);
    send_string(6, 0);
    drain();

    // Full-length and overflowing strings, including one ended by a dropped byte.
    send_string(32, 0);
    send_string(33, 1);
    drain();

    // A stretch with no idling on either side.
    send_idle_on = 0;
    recv_idle_on = 0;
    for (int s = 0; s < 4; s++) send_string($urandom_range(8, 1), s[0]);
    drain();
    send_idle_on = 1;
    recv_idle_on = 1;

    // Random strings, mostly short, now and then long enough to overflow.
    while (items_sent < 160) begin
      if ($urandom_range(9) == 0) n = $urandom_range(36, 28);
      else n = $urandom_range(10, 1);
      send_string(n, $urandom_range(1));
    end
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
